// ===== src/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Shared widths, command and status codes, slot states and controller states.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int FUNC_W   = 3;
  localparam int PID_W    = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  localparam int TASKS_DEF = 16;
  localparam logic [PID_W-1:0] MAX_PID_RESET = 16'hFFFF;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK  = 3'd0,
    FN_SPAWN = 3'd1,
    FN_WAIT  = 3'd2,
    FN_WAKE  = 3'd3,
    FN_KILL  = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_IDLE      = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2,
    SLOT_WAITING = 2'd3
  } slot_st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_CUR,
    S_TICK_WALK,
    S_WAIT_WR,
    S_SPAWN_SCAN,
    S_SPAWN_NEXT,
    S_FIND,
    S_FIND_EVAL,
    S_MISS,
    S_DONE
  } fsm_t;

endpackage

// ===== src/rrts_if.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler channels
// Command channel and result channel, each a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrts_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [rrts_pkg::FUNC_W-1:0] func;
  logic [rrts_pkg::PID_W-1:0]  pid;

  modport source (output valid, output func, output pid, input ready);
  modport sink   (input valid, input func, input pid, output ready);
endinterface

interface rrts_res_if;
  logic                          valid;
  logic                          ready;
  logic [rrts_pkg::STATUS_W-1:0] status_code;
  logic                          running_valid;
  logic [rrts_pkg::PID_W-1:0]    running_pid;
  logic [rrts_pkg::SLOT_W-1:0]   running_slot;
  logic [rrts_pkg::PID_W-1:0]    spawned_pid;

  modport source (output valid, output status_code, output running_valid,
                  output running_pid, output running_slot, output spawned_pid,
                  input ready);
  modport sink   (input valid, input status_code, input running_valid,
                  input running_pid, input running_slot, input spawned_pid,
                  output ready);
endinterface

// ===== src/round_robin_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler core
// Task table in one synchronous memory, walked by a sequencer one slot a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   cmd: one beat per command (func, pid). res: exactly one beat per command
//   with status, the running task after the command and the spawned pid.
//   cfg_wr_en/cfg_wr_data write max_pid; write it only while the core is idle.
// Sequence per command, from the command beat to the result:
//   tick        reads the cursor entry, if any, then walks toward older
//               slots, wrapping to the newest, until a ready task
//   wait        writes the running task back as waiting, if one runs
//   wake, kill  walk the task list from the newest task for the pid
//   spawn       scans for the lowest free slot, then per pid candidate (at
//               most TASKS + 1) walks the list; places the task on a miss
//   The list walk reads one entry of the task memory per cycle. One
//   command is in flight at a time.
// Reset: all slots free, no running task, pid counter zero, max_pid 65535.
//   The memory itself is not cleared; an occupancy bit per slot covers it.
// Stall: the result sits in an output register. The next command is taken
//   while it waits, and that command's result holds in the sequencer until
//   the output register frees up.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core #(
  parameter int TASKS = rrts_pkg::TASKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [rrts_pkg::PID_W-1:0] cfg_wr_data,
  rrts_cmd_if.sink                   cmd,
  rrts_res_if.source                 res
);

  localparam int IW = $clog2(TASKS);          // slot index width
  localparam int LW = IW + 1;                 // link width, with room for "none"
  localparam int TW = $clog2(TASKS + 2);      // pid candidate counter
  localparam int PW = rrts_pkg::PID_W;
  localparam int SW = rrts_pkg::SLOT_W;
  localparam logic [LW-1:0] NONE = LW'(TASKS);

  typedef struct packed {
    rrts_pkg::slot_st_t st;
    logic [PW-1:0]      id;
    logic [LW-1:0]      link;   // next older task
  } entry_t;

  function automatic logic is_none(logic [LW-1:0] x);
    return x >= NONE;
  endfunction

  // Task memory: one write port, one read port, registered read data
  entry_t        mem [TASKS];
  entry_t        rdata;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_wdata;

  // Control state
  rrts_pkg::fsm_t    fsm, fsm_next;
  rrts_pkg::func_t   op, op_next;
  logic [PW-1:0]     max_pid;
  logic [PW-1:0]     pid_counter, pid_counter_next;
  logic [LW-1:0]     newest, newest_next;
  logic [LW-1:0]     cursor, cursor_next;
  logic              cur_running, cur_running_next;
  logic [TASKS-1:0]  occupied, occupied_next;
  logic              out_valid, out_valid_next;

  // Working registers
  logic [PW-1:0]     key, key_next;
  logic [PW-1:0]     cur_pid, cur_pid_next;
  logic [IW-1:0]     ptr, ptr_next;
  logic [LW-1:0]     prev, prev_next;
  entry_t            prev_entry, prev_entry_next;
  logic [IW-1:0]     free_slot, free_slot_next;
  logic [IW-1:0]     scan, scan_next;
  logic [IW-1:0]     walk_cnt, walk_cnt_next;
  logic [PW-1:0]     cand, cand_next;
  logic [TW-1:0]     tries, tries_next;
  rrts_pkg::status_t status, status_next;
  logic [PW-1:0]     spawned, spawned_next;

  // Output register
  rrts_pkg::status_t out_status, out_status_next;
  logic              out_run_valid, out_run_valid_next;
  logic [PW-1:0]     out_run_pid, out_run_pid_next;
  logic [SW-1:0]     out_run_slot, out_run_slot_next;
  logic [PW-1:0]     out_spawned, out_spawned_next;

  logic [PW-1:0]     lim;
  logic [LW-1:0]     nxt;

  // Pids live below lim; a max_pid of zero acts as one
  assign lim = (max_pid == '0) ? PW'(1) : max_pid;

  // Memory: forward the write when it hits the address being read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      rdata <= mem_wdata;
    end else begin
      rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    fsm_next           = fsm;
    op_next            = op;
    pid_counter_next   = pid_counter;
    newest_next        = newest;
    cursor_next        = cursor;
    cur_running_next   = cur_running;
    occupied_next      = occupied;
    out_valid_next     = out_valid;
    key_next           = key;
    cur_pid_next       = cur_pid;
    ptr_next           = ptr;
    prev_next          = prev;
    prev_entry_next    = prev_entry;
    free_slot_next     = free_slot;
    scan_next          = scan;
    walk_cnt_next      = walk_cnt;
    cand_next          = cand;
    tries_next         = tries;
    status_next        = status;
    spawned_next       = spawned;
    out_status_next    = out_status;
    out_run_valid_next = out_run_valid;
    out_run_pid_next   = out_run_pid;
    out_run_slot_next  = out_run_slot;
    out_spawned_next   = out_spawned;
    mem_we             = 1'b0;
    mem_waddr          = ptr;
    mem_wdata          = rdata;
    mem_raddr          = ptr;
    nxt                = NONE;
    cmd.ready          = (fsm == rrts_pkg::S_IDLE);

    // Drop the output beat once taken
    if (out_valid && res.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (fsm)
      rrts_pkg::S_IDLE: begin
        if (cmd.valid) begin
          op_next      = rrts_pkg::func_t'(cmd.func);
          key_next     = cmd.pid;
          status_next  = rrts_pkg::STS_OK;
          spawned_next = '0;
          unique case (cmd.func)
            rrts_pkg::FN_TICK: begin
              if (!is_none(cursor)) begin
                mem_raddr = cursor[IW-1:0];
                ptr_next  = cursor[IW-1:0];
                fsm_next  = rrts_pkg::S_TICK_CUR;
              end else if (!is_none(newest)) begin
                mem_raddr     = newest[IW-1:0];
                ptr_next      = newest[IW-1:0];
                walk_cnt_next = '0;
                fsm_next      = rrts_pkg::S_TICK_WALK;
              end else begin
                cursor_next      = NONE;
                cur_running_next = 1'b0;
                status_next      = rrts_pkg::STS_IDLE;
                fsm_next         = rrts_pkg::S_DONE;
              end
            end
            rrts_pkg::FN_SPAWN: begin
              scan_next = '0;
              fsm_next  = rrts_pkg::S_SPAWN_SCAN;
            end
            rrts_pkg::FN_WAIT: begin
              if (cur_running) begin
                mem_raddr = cursor[IW-1:0];
                ptr_next  = cursor[IW-1:0];
                fsm_next  = rrts_pkg::S_WAIT_WR;
              end else begin
                status_next = rrts_pkg::STS_IDLE;
                fsm_next    = rrts_pkg::S_DONE;
              end
            end
            rrts_pkg::FN_WAKE, rrts_pkg::FN_KILL: begin
              fsm_next = rrts_pkg::S_FIND;
            end
            default: begin
              fsm_next = rrts_pkg::S_DONE;
            end
          endcase
        end
      end

      // Cursor entry is in: hand a running cursor back to ready, step older
      rrts_pkg::S_TICK_CUR: begin
        if (cur_running) begin
          mem_we           = 1'b1;
          mem_wdata.st     = rrts_pkg::SLOT_READY;
          cur_running_next = 1'b0;
        end
        nxt = is_none(rdata.link) ? newest : rdata.link;
        if (is_none(nxt)) begin
          cursor_next = NONE;
          status_next = rrts_pkg::STS_IDLE;
          fsm_next    = rrts_pkg::S_DONE;
        end else begin
          mem_raddr     = nxt[IW-1:0];
          ptr_next      = nxt[IW-1:0];
          walk_cnt_next = '0;
          fsm_next      = rrts_pkg::S_TICK_WALK;
        end
      end

      // Walk toward older tasks, wrapping to the newest, until a ready one
      rrts_pkg::S_TICK_WALK: begin
        nxt = is_none(rdata.link) ? newest : rdata.link;
        if (rdata.st == rrts_pkg::SLOT_READY) begin
          mem_we           = 1'b1;
          mem_wdata.st     = rrts_pkg::SLOT_RUNNING;
          cursor_next      = {1'b0, ptr};
          cur_running_next = 1'b1;
          cur_pid_next     = rdata.id;
          fsm_next         = rrts_pkg::S_DONE;
        end else if ((walk_cnt == IW'(TASKS - 1)) || is_none(nxt)) begin
          cursor_next      = NONE;
          cur_running_next = 1'b0;
          status_next      = rrts_pkg::STS_IDLE;
          fsm_next         = rrts_pkg::S_DONE;
        end else begin
          walk_cnt_next = walk_cnt + IW'(1);
          mem_raddr     = nxt[IW-1:0];
          ptr_next      = nxt[IW-1:0];
        end
      end

      rrts_pkg::S_WAIT_WR: begin
        mem_we           = 1'b1;
        mem_wdata.st     = rrts_pkg::SLOT_WAITING;
        cur_running_next = 1'b0;
        fsm_next         = rrts_pkg::S_DONE;
      end

      // Look for the lowest free slot, one per cycle
      rrts_pkg::S_SPAWN_SCAN: begin
        if (!occupied[scan]) begin
          free_slot_next = scan;
          cand_next      = pid_counter;
          if ({1'b0, lim} < 17'(TASKS + 1)) begin
            tries_next = TW'(lim);
          end else begin
            tries_next = TW'(TASKS + 1);
          end
          fsm_next = rrts_pkg::S_SPAWN_NEXT;
        end else if (scan == IW'(TASKS - 1)) begin
          status_next = rrts_pkg::STS_FULL;
          fsm_next    = rrts_pkg::S_DONE;
        end else begin
          scan_next = scan + IW'(1);
        end
      end

      rrts_pkg::S_SPAWN_NEXT: begin
        key_next = (cand >= lim) ? '0 : cand;
        fsm_next = rrts_pkg::S_FIND;
      end

      rrts_pkg::S_FIND: begin
        prev_next = NONE;
        if (is_none(newest)) begin
          fsm_next = rrts_pkg::S_MISS;
        end else begin
          mem_raddr = newest[IW-1:0];
          ptr_next  = newest[IW-1:0];
          fsm_next  = rrts_pkg::S_FIND_EVAL;
        end
      end

      rrts_pkg::S_FIND_EVAL: begin
        if ((rdata.st != rrts_pkg::SLOT_FREE) && (rdata.id == key)) begin
          case (op)
            rrts_pkg::FN_WAKE: begin
              if (rdata.st == rrts_pkg::SLOT_WAITING) begin
                mem_we       = 1'b1;
                mem_wdata.st = rrts_pkg::SLOT_READY;
              end
              fsm_next = rrts_pkg::S_DONE;
            end
            rrts_pkg::FN_KILL: begin
              // Unlink: the newer neighbor, or the head, skips this slot
              if (is_none(prev)) begin
                newest_next = rdata.link;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = prev[IW-1:0];
                mem_wdata      = prev_entry;
                mem_wdata.link = rdata.link;
              end
              occupied_next[ptr] = 1'b0;
              if (cursor == {1'b0, ptr}) begin
                cursor_next      = NONE;
                cur_running_next = 1'b0;
              end
              fsm_next = rrts_pkg::S_DONE;
            end
            default: begin
              // Spawn: candidate pid taken, try the next one
              if (tries == TW'(1)) begin
                pid_counter_next = key + PW'(1);
                status_next      = rrts_pkg::STS_FULL;
                fsm_next         = rrts_pkg::S_DONE;
              end else begin
                cand_next  = key + PW'(1);
                tries_next = tries - TW'(1);
                fsm_next   = rrts_pkg::S_SPAWN_NEXT;
              end
            end
          endcase
        end else begin
          prev_next       = {1'b0, ptr};
          prev_entry_next = rdata;
          if (is_none(rdata.link)) begin
            fsm_next = rrts_pkg::S_MISS;
          end else begin
            mem_raddr = rdata.link[IW-1:0];
            ptr_next  = rdata.link[IW-1:0];
          end
        end
      end

      rrts_pkg::S_MISS: begin
        if (op == rrts_pkg::FN_SPAWN) begin
          // Place the new ready task at the head
          mem_we                   = 1'b1;
          mem_waddr                = free_slot;
          mem_wdata.st             = rrts_pkg::SLOT_READY;
          mem_wdata.id             = key;
          mem_wdata.link           = newest;
          occupied_next[free_slot] = 1'b1;
          newest_next              = {1'b0, free_slot};
          pid_counter_next         = key + PW'(1);
          spawned_next             = key;
        end else begin
          status_next = rrts_pkg::STS_NOT_FOUND;
        end
        fsm_next = rrts_pkg::S_DONE;
      end

      // Hold the result until the output register is free
      rrts_pkg::S_DONE: begin
        if (!out_valid || res.ready) begin
          out_valid_next     = 1'b1;
          out_status_next    = status;
          out_run_valid_next = cur_running;
          out_run_pid_next   = cur_running ? cur_pid : '0;
          out_run_slot_next  = cur_running ? SW'(cursor[IW-1:0]) : '0;
          out_spawned_next   = spawned;
          fsm_next           = rrts_pkg::S_IDLE;
        end
      end

      default: begin
        fsm_next = rrts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm         <= rrts_pkg::S_IDLE;
      max_pid     <= rrts_pkg::MAX_PID_RESET;
      pid_counter <= '0;
      newest      <= NONE;
      cursor      <= NONE;
      cur_running <= 1'b0;
      occupied    <= '0;
      out_valid   <= 1'b0;
    end else begin
      fsm         <= fsm_next;
      pid_counter <= pid_counter_next;
      newest      <= newest_next;
      cursor      <= cursor_next;
      cur_running <= cur_running_next;
      occupied    <= occupied_next;
      out_valid   <= out_valid_next;
      if (cfg_wr_en) begin
        max_pid <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op            <= op_next;
    key           <= key_next;
    cur_pid       <= cur_pid_next;
    ptr           <= ptr_next;
    prev          <= prev_next;
    prev_entry    <= prev_entry_next;
    free_slot     <= free_slot_next;
    scan          <= scan_next;
    walk_cnt      <= walk_cnt_next;
    cand          <= cand_next;
    tries         <= tries_next;
    status        <= status_next;
    spawned       <= spawned_next;
    out_status    <= out_status_next;
    out_run_valid <= out_run_valid_next;
    out_run_pid   <= out_run_pid_next;
    out_run_slot  <= out_run_slot_next;
    out_spawned   <= out_spawned_next;
  end

  assign res.valid         = out_valid;
  assign res.status_code   = out_status;
  assign res.running_valid = out_run_valid;
  assign res.running_pid   = out_run_pid;
  assign res.running_slot  = out_run_slot;
  assign res.spawned_pid   = out_spawned;

  // An empty list means no slot is held
  a_empty_list_no_slots: assert property (@(posedge clk) disable iff (rst)
    is_none(newest) |-> (occupied == '0))
    else $error("task list empty while slots are occupied");

  // A running task needs a cursor
  a_running_has_cursor: assert property (@(posedge clk) disable iff (rst)
    cur_running |-> !is_none(cursor))
    else $error("running flag set without a cursor");

  // A spawned pid is only reported with an ok status
  a_spawn_status: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.spawned_pid != '0)) |-> (res.status_code == rrts_pkg::STS_OK))
    else $error("spawned pid reported with an error status");

endmodule

// ===== dv/rrts_sched_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler result checker
// Watches the command and result channels of the task scheduler, keeps its
// own copy of the task table and compares every result beat, field by field,
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module rrts_sched_checker #(
  parameter int TASKS = rrts_pkg::TASKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [rrts_pkg::PID_W-1:0] cfg_wr_data,
  rrts_cmd_if                        cmd,
  rrts_res_if                        res,
  output int                         fail_count,
  output int                         pending
);
  import rrts_pkg::*;

  localparam int NO_SLOT = TASKS;

  typedef struct packed {
    status_t           status;
    logic              run_valid;
    logic [PID_W-1:0]  run_pid;
    logic [SLOT_W-1:0] run_slot;
    logic [PID_W-1:0]  new_pid;
  } sched_result_t;

  slot_st_t         tbl_state [TASKS];
  logic [PID_W-1:0] tbl_pid   [TASKS];
  int               tbl_older [TASKS];
  int               head_slot;
  int               cursor_slot;
  logic [PID_W-1:0] next_pid;
  logic [PID_W-1:0] pid_limit;
  sched_result_t    result_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("check: %s got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  function automatic int older_of(input int s);
    if (s >= TASKS) return NO_SLOT;
    return (tbl_older[s] >= TASKS) ? NO_SLOT : tbl_older[s];
  endfunction

  // walk from the newest task; also hand back the newer neighbour
  function automatic int locate_pid(input logic [PID_W-1:0] p, output int newer);
    int s;
    int prv;
    int n;
    s = head_slot;
    prv = NO_SLOT;
    newer = NO_SLOT;
    for (n = 0; n < TASKS && s < TASKS; n++) begin
      if (tbl_state[s] != SLOT_FREE && tbl_pid[s] == p) begin
        newer = prv;
        return s;
      end
      prv = s;
      s = older_of(s);
    end
    return NO_SLOT;
  endfunction

  function automatic status_t rotate_schedule();
    int s;
    int n;
    if (cursor_slot < TASKS) begin
      if (tbl_state[cursor_slot] == SLOT_RUNNING) tbl_state[cursor_slot] = SLOT_READY;
      s = older_of(cursor_slot);
      if (s >= TASKS) s = head_slot;
    end else begin
      s = head_slot;
    end
    for (n = 0; n < TASKS && s < TASKS; n++) begin
      if (tbl_state[s] == SLOT_READY) begin
        tbl_state[s] = SLOT_RUNNING;
        cursor_slot = s;
        return STS_OK;
      end
      s = older_of(s);
      if (s >= TASKS) s = head_slot;
    end
    cursor_slot = NO_SLOT;
    return STS_IDLE;
  endfunction

  function automatic status_t spawn_task(output logic [PID_W-1:0] given);
    int free_slot;
    int lim;
    int tries;
    int c;
    int nb;
    int s;
    given = '0;
    free_slot = NO_SLOT;
    for (s = TASKS - 1; s >= 0; s--) begin
      if (tbl_state[s] == SLOT_FREE) free_slot = s;
    end
    if (free_slot >= TASKS) return STS_FULL;
    lim = (pid_limit == '0) ? 1 : int'(pid_limit);
    tries = (lim < TASKS + 1) ? lim : TASKS + 1;
    c = int'(next_pid);
    while (tries > 0) begin
      if (c >= lim) c = 0;
      if (locate_pid(PID_W'(c), nb) >= TASKS) begin
        tbl_pid[free_slot]   = PID_W'(c);
        tbl_state[free_slot] = SLOT_READY;
        tbl_older[free_slot] = head_slot;
        head_slot = free_slot;
        next_pid = PID_W'(c + 1);
        given = PID_W'(c);
        return STS_OK;
      end
      c++;
      tries--;
    end
    next_pid = PID_W'(c);
    return STS_FULL;
  endfunction

  function automatic sched_result_t apply_command(input logic [FUNC_W-1:0] f,
                                                  input logic [PID_W-1:0] p);
    sched_result_t r;
    int s;
    int nb;
    r = '0;
    r.status = STS_OK;
    case (f)
      FN_TICK:  r.status = rotate_schedule();
      FN_SPAWN: r.status = spawn_task(r.new_pid);
      FN_WAIT: begin
        if (cursor_slot < TASKS && tbl_state[cursor_slot] == SLOT_RUNNING)
          tbl_state[cursor_slot] = SLOT_WAITING;
        else
          r.status = STS_IDLE;
      end
      FN_WAKE: begin
        s = locate_pid(p, nb);
        if (s >= TASKS) r.status = STS_NOT_FOUND;
        else if (tbl_state[s] == SLOT_WAITING) tbl_state[s] = SLOT_READY;
      end
      FN_KILL: begin
        s = locate_pid(p, nb);
        if (s >= TASKS) begin
          r.status = STS_NOT_FOUND;
        end else begin
          if (nb < TASKS) tbl_older[nb] = older_of(s);
          else head_slot = older_of(s);
          tbl_state[s] = SLOT_FREE;
          if (cursor_slot == s) cursor_slot = NO_SLOT;
        end
      end
      default: ;
    endcase
    r.run_valid = cursor_slot < TASKS && tbl_state[cursor_slot] == SLOT_RUNNING;
    if (r.run_valid) begin
      r.run_pid  = tbl_pid[cursor_slot];
      r.run_slot = SLOT_W'(cursor_slot);
    end
    return r;
  endfunction

  task automatic clear_table();
    int s;
    for (s = 0; s < TASKS; s++) begin
      tbl_state[s] = SLOT_FREE;
      tbl_pid[s]   = '0;
      tbl_older[s] = 0;
    end
    head_slot   = NO_SLOT;
    cursor_slot = NO_SLOT;
    next_pid    = '0;
    pid_limit   = MAX_PID_RESET;
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      clear_table();
      result_q.delete();
    end else begin
      if (cfg_wr_en) pid_limit = cfg_wr_data;
      if (cmd.valid && cmd.ready) result_q.push_back(apply_command(cmd.func, cmd.pid));
      if (res.valid && res.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result beat with no command pending", '0, '0);
        end else begin
          want = result_q.pop_front();
          if (res.status_code !== want.status)
            report_mismatch("status_code", 32'(res.status_code), 32'(want.status));
          if (res.running_valid !== want.run_valid)
            report_mismatch("running_valid", 32'(res.running_valid),
                            32'(want.run_valid));
          if (res.running_pid !== want.run_pid)
            report_mismatch("running_pid", 32'(res.running_pid), 32'(want.run_pid));
          if (res.running_slot !== want.run_slot)
            report_mismatch("running_slot", 32'(res.running_slot),
                            32'(want.run_slot));
          if (res.spawned_pid !== want.new_pid)
            report_mismatch("spawned_pid", 32'(res.spawned_pid), 32'(want.new_pid));
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== dv/round_robin_task_scheduler_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task scheduler core testbench
// Drives scheduler commands with random sender gaps and receiver stalls,
// sweeps the pid limit through several settings between phases, and lets the
// checker beside the core predict and compare every result beat.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core_test;
  import rrts_pkg::*;

  localparam int TASKS        = TASKS_DEF;
  // slowest beat: spawn walking every pid candidate, plus longest gap and stall
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 160;
  localparam int POOL_DEPTH   = 16;

  // func codes past kill do nothing in the core; still drive them
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = FUNC_W'(FN_KILL + 1);
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = '1;

  // command mixes for the random part
  localparam int MIX_EVEN  = 0;
  localparam int MIX_FILL  = 1;
  localparam int MIX_DRAIN = 2;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [PID_W-1:0] cfg_wr_data;

  int               fail_count;
  int               pending;
  int               cycle_count;

  // knobs for gaps on the command side and stalls on the result side
  logic             allow_gap;
  logic             allow_stall;

  // pid limit currently programmed, and recently spawned pids to aim at
  logic [PID_W-1:0] cur_limit;
  logic [PID_W-1:0] pid_pool [POOL_DEPTH];
  int               pool_wr;
  int               pool_count;

  rrts_cmd_if cmd ();
  rrts_res_if res ();

  round_robin_task_scheduler_core #(
    .TASKS (TASKS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .res         (res)
  );

  rrts_sched_checker #(
    .TASKS (TASKS)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .res         (res),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run at a limit well past the slowest legal one.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Result side: hold ready low for random stretches while stalls are allowed.
  initial begin
    int stall_left;
    stall_left = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res.ready = 1'b0;
        stall_left--;
      end else begin
        res.ready = 1'b1;
        if (allow_stall && $urandom_range(0, 99) < 25) stall_left = pick_pause();
      end
    end
  end

  // Remember spawned pids so that wake and kill mostly hit live tasks.
  // Pid zero is never recorded here; the low random range covers it.
  always @(posedge clk) begin
    if (rst) begin
      pool_wr    <= 0;
      pool_count <= 0;
    end else if (res.valid && res.ready && res.status_code == STS_OK &&
                 res.spawned_pid != '0) begin
      pid_pool[pool_wr] <= res.spawned_pid;
      pool_wr           <= (pool_wr + 1) % POOL_DEPTH;
      if (pool_count < POOL_DEPTH) pool_count <= pool_count + 1;
    end
  end

  function automatic logic [PID_W-1:0] pick_pid();
    int r;
    int span;
    r = $urandom_range(0, 99);
    span = (cur_limit < 64) ? int'(cur_limit) : 64;
    if (r < 70 && pool_count > 0) return pid_pool[$urandom_range(0, pool_count - 1)];
    if (r < 90) return PID_W'($urandom_range(0, span));
    return PID_W'($urandom_range(0, 65535));
  endfunction

  // Send one command beat. Called at a falling edge; returns at the falling
  // edge after the beat, with valid still high so the next beat can follow
  // back to back.
  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [PID_W-1:0] p);
    int gap;
    gap = (allow_gap && $urandom_range(0, 99) < 30) ? pick_pause() : 0;
    if (gap > 0) begin
      cmd.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid = 1'b1;
    cmd.func  = f;
    cmd.pid   = p;
    do @(posedge clk); while (!cmd.ready);
    @(negedge clk);
  endtask

  // Drop valid, let every result drain, then program a new pid limit.
  task automatic set_pid_limit(input logic [PID_W-1:0] lim);
    cmd.valid = 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = lim;
    cur_limit   = lim;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // One random command under the given mix. Spare func codes are ignored by
  // the core and do not count toward the phase length.
  task automatic issue_random(input int mix, output bit counted);
    int r;
    int w_spawn;
    int w_kill;
    logic [FUNC_W-1:0] f;
    w_spawn = (mix == MIX_EVEN) ? 22 : (mix == MIX_FILL) ? 40 : 12;
    w_kill  = (mix == MIX_EVEN) ? 16 : (mix == MIX_FILL) ? 8  : 26;
    r = $urandom_range(0, 99);
    if (r < 3)                                 f = FUNC_W'($urandom_range(FN_SPARE_LO,
                                                                          FN_SPARE_HI));
    else if (r < 3 + w_spawn)                  f = FN_SPAWN;
    else if (r < 3 + w_spawn + w_kill)         f = FN_KILL;
    else if (r < 3 + w_spawn + w_kill + 15)    f = FN_WAKE;
    else if (r < 3 + w_spawn + w_kill + 27)    f = FN_WAIT;
    else                                       f = FN_TICK;
    counted = (f <= FN_KILL);
    send_cmd(f, pick_pid());
  endtask

  initial begin
    int ph;
    int done;
    bit counted;
    logic [PID_W-1:0] lim;

    // Drive every input to a known value before the first edge.
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    cmd.valid   = 1'b0;
    cmd.func    = FN_TICK;
    cmd.pid     = '0;
    allow_gap   = 1'b0;
    allow_stall = 1'b0;
    cur_limit   = MAX_PID_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty table, absent pids, spare codes, then a small
    // table walked through wait, wake, wrap-around and kill of the runner.
    set_pid_limit(MAX_PID_RESET);
    send_cmd(FN_TICK, '0);          // nothing ready: idle
    send_cmd(FN_WAIT, '0);          // nothing running
    send_cmd(FN_WAKE, '0);          // absent pid
    send_cmd(FN_KILL, '1);          // absent pid, all ones
    send_cmd(FN_SPARE_LO, '1);
    send_cmd(FN_SPARE_HI, '0);
    send_cmd(FN_SPAWN, '0);         // pid 0
    send_cmd(FN_SPAWN, '1);         // pid 1
    send_cmd(FN_SPAWN, '0);         // pid 2
    send_cmd(FN_TICK, '0);          // no cursor: newest runs
    send_cmd(FN_WAKE, PID_W'(1));   // wake of a ready task
    send_cmd(FN_WAIT, '0);          // park the runner
    send_cmd(FN_TICK, '0);          // waiting task stays waiting
    send_cmd(FN_TICK, '0);
    send_cmd(FN_TICK, '0);          // wrap from oldest back to newest
    send_cmd(FN_WAKE, PID_W'(2));
    send_cmd(FN_KILL, PID_W'(1));   // kill the runner: cursor cleared
    send_cmd(FN_TICK, '0);
    send_cmd(FN_KILL, PID_W'(0));   // unlink the oldest
    send_cmd(FN_WAIT, '0);
    send_cmd(FN_TICK, '0);          // only a waiting task left: idle
    send_cmd(FN_WAKE, PID_W'(2));
    send_cmd(FN_TICK, '0);
    send_cmd(FN_KILL, PID_W'(2));   // table empty again
    send_cmd(FN_WAIT, '0);

    // Random part: sweep the pid limit, extremes included; zero acts as one.
    // Rotate the mix so the table both fills up and empties out.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       lim = MAX_PID_RESET;
        1:       lim = PID_W'(20);
        2:       lim = PID_W'(1);
        3:       lim = '0;
        4:       lim = PID_W'(3);
        5:       lim = PID_W'(TASKS + 1);
        6:       lim = PID_W'(TASKS);
        7:       lim = MAX_PID_RESET - 1;
        8:       lim = PID_W'($urandom_range(2, 64));
        default: lim = PID_W'($urandom_range(1, 65535));
      endcase
      set_pid_limit(lim);
      done = 0;
      while (done < PHASE_ITEMS) begin
        // Re-roll the idle knobs now and then; leave some stretches clean.
        if (done % 40 == 0) begin
          allow_gap   = ($urandom_range(0, 99) < 75);
          allow_stall = ($urandom_range(0, 99) < 75);
        end
        issue_random(ph % 3, counted);
        if (counted) done++;
      end
    end

    // Drain: drop valid, wait out every result, then a margin for stray beats.
    cmd.valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
